/* rtl/tia_pkg.sv */
`timescale 1ns / 1ps
package tia_pkg;

	// Fixed width of the index and corner ports
	localparam int unsigned VERTEX_BITS = 32;

	// Defaults for the top-level parameters
	localparam int unsigned INDEX_BITS_DEFAULT  = 32;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	// Configuration register file: two one-bit registers
	localparam int unsigned CFG_DATA_BITS = 1;
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t REG_LIST_MODE  = 1'b0;
	localparam cfg_index_t REG_OFFSET_ODD = 1'b1;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

/* rtl/triangle_index_assembler_top.sv */
`timescale 1ns / 1ps
// An item that completes a triangle enters the queue at the accepting edge, then moves into
// the output register once that register is free; it is popped from there.
// Throughput: one item per cycle unless the queue is full; the front history update and the
// back output register each take one item a cycle; the QUEUE_DEPTH queue absorbs result stalls.
// Reset: arst_n clears history, configuration (strip mode, even offset), queue and output valid.
// Memory contents need no reset; nothing is read before it is written.
module triangle_index_assembler_top #(
	parameter int unsigned INDEX_BITS  = tia_pkg::INDEX_BITS_DEFAULT,
	parameter int unsigned QUEUE_DEPTH = tia_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  tia_pkg::cfg_index_t                   cfg_index,
	input  logic [tia_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic [tia_pkg::VERTEX_BITS-1:0]       vertex_index,
	input  logic                                  restart,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [tia_pkg::VERTEX_BITS-1:0]       corner_a,
	output logic [tia_pkg::VERTEX_BITS-1:0]       corner_b,
	output logic [tia_pkg::VERTEX_BITS-1:0]       corner_c
);
	import tia_pkg::*;

	localparam int unsigned TRI_BITS = 3 * INDEX_BITS;

	q_status_t            q_status;
	logic                 tri_push;
	logic [TRI_BITS-1:0]  tri_data;
	logic                 q_pop;
	logic [TRI_BITS-1:0]  q_data;

	// Front: hold the last two indices, count the partition, apply strip winding
	// and push each completed triangle, degenerate or not, into the queue.
	tia_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.vertex_index (vertex_index),
		.restart      (restart),
		.q_status     (q_status),
		.tri_push     (tri_push),
		.tri_data     (tri_data)
	);

	// Queue: decouple the front from result-side stalls; full backs up to the input.
	tia_queue #(
		.WIDTH (TRI_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tri_push),
		.wr_data (tri_data),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.status  (q_status)
	);

	// Back: drop degenerate triangles and hold the next one in the output register
	// until it is popped; advance from the queue whenever that register frees up.
	tia_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.corner_a (corner_a),
		.corner_b (corner_b),
		.corner_c (corner_c)
	);

	// Input item stalls only while the queue is full.
	assign full = q_status.full;

endmodule

/* rtl/tia_front.sv */
`timescale 1ns / 1ps
module tia_front #(
	parameter int unsigned INDEX_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  tia_pkg::cfg_index_t           cfg_index,
	input  logic [tia_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                          push,
	input  logic [tia_pkg::VERTEX_BITS-1:0] vertex_index,
	input  logic                          restart,
	input  tia_pkg::q_status_t            q_status,
	output logic                          tri_push,
	output logic [3*INDEX_BITS-1:0]       tri_data
);
	import tia_pkg::*;

	logic                  list_mode_q;
	logic                  offset_odd_q;
	logic [INDEX_BITS-1:0] older_q;
	logic [INDEX_BITS-1:0] newer_q;
	logic [1:0]            seen_q;
	logic                  parity_q;

	logic                  accept;
	logic [INDEX_BITS-1:0] cur;
	logic [1:0]            seen_eff;
	logic                  parity_eff;
	logic                  have;
	logic                  swap;
	logic [1:0]            seen_next;
	logic [INDEX_BITS-1:0] corner_b_c;
	logic [INDEX_BITS-1:0] corner_c_c;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_mode_q  <= 1'b0;
			offset_odd_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LIST_MODE:  list_mode_q  <= cfg_data[0];
				REG_OFFSET_ODD: offset_odd_q <= cfg_data[0];
			endcase
		end
	end

	assign accept     = push && !q_status.full;
	assign cur        = vertex_index[INDEX_BITS-1:0];
	assign seen_eff   = restart ? 2'd0 : seen_q;
	assign parity_eff = restart ? 1'b0 : parity_q;
	assign have       = seen_eff[1];
	assign swap       = !list_mode_q && (parity_eff ^ offset_odd_q);

	always_comb begin
		if (!have)
			seen_next = seen_eff + 2'd1;
		else if (list_mode_q)
			seen_next = 2'd0;
		else
			seen_next = seen_eff;
	end

	assign corner_b_c = swap ? cur : newer_q;
	assign corner_c_c = swap ? newer_q : cur;
	assign tri_push   = accept && have;
	assign tri_data   = {older_q, corner_b_c, corner_c_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 2'd0;
			parity_q <= 1'b0;
		end else if (accept) begin
			seen_q   <= seen_next;
			parity_q <= !parity_eff;
		end
	end

	// History indices, reset to zero as the partition history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
		end else if (accept) begin
			older_q <= newer_q;
			newer_q <= cur;
		end
	end

	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != 2'd3)
		else $error("history count out of range");

endmodule

/* rtl/tia_queue.sv */
`timescale 1ns / 1ps
module tia_queue #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [WIDTH-1:0]   wr_data,
	input  logic               rd_en,
	output logic [WIDTH-1:0]   rd_data,
	output tia_pkg::q_status_t status
);
	import tia_pkg::*;

	localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

	logic [WIDTH-1:0]    slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_wr;
	logic                do_rd;

	assign status.full      = (count_q == FULL_CNT);
	assign status.not_empty = (count_q != '0);
	assign do_wr   = wr_en && !status.full;
	assign do_rd   = rd_en && status.not_empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on write");

endmodule

/* rtl/tia_back.sv */
`timescale 1ns / 1ps
module tia_back #(
	parameter int unsigned INDEX_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tia_pkg::q_status_t              q_status,
	input  logic [3*INDEX_BITS-1:0]         q_data,
	output logic                            q_pop,
	input  logic                            pop,
	output logic                            empty,
	output logic [tia_pkg::VERTEX_BITS-1:0] corner_a,
	output logic [tia_pkg::VERTEX_BITS-1:0] corner_b,
	output logic [tia_pkg::VERTEX_BITS-1:0] corner_c
);
	import tia_pkg::*;

	logic [INDEX_BITS-1:0] a_c;
	logic [INDEX_BITS-1:0] b_c;
	logic [INDEX_BITS-1:0] c_c;
	logic                  keep;
	logic                  take;
	logic                  out_valid_q;
	logic [INDEX_BITS-1:0] a_q;
	logic [INDEX_BITS-1:0] b_q;
	logic [INDEX_BITS-1:0] c_q;

	assign {a_c, b_c, c_c} = q_data;
	// drop triangles with two equal corners
	assign keep  = (a_c != b_c) && (a_c != c_c) && (b_c != c_c);
	assign take  = !out_valid_q || pop;
	assign q_pop = q_status.not_empty && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= q_pop && keep;
	end

	always_ff @(posedge clk) begin
		if (q_pop && keep) begin
			a_q <= a_c;
			b_q <= b_c;
			c_q <= c_c;
		end
	end

	assign empty    = !out_valid_q;
	assign corner_a = VERTEX_BITS'(a_q);
	assign corner_b = VERTEX_BITS'(b_q);
	assign corner_c = VERTEX_BITS'(c_q);

	a_no_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (a_q != b_q && a_q != c_q && b_q != c_q))
		else $error("degenerate triangle offered");

endmodule
